### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL; itp_back.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/itp_pkg.sv
package itp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AND   = 8'h26;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_IMPL  = 8'h3E;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_OR    = 8'h7C;

  localparam logic [1:0] PREC_NONE = 2'd0;
  localparam logic [1:0] PREC_LOW  = 2'd2;
  localparam logic [1:0] PREC_HIGH = 2'd3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_CHAR,
    CMD_OPEN,
    CMD_CLOSE,
    CMD_OPER,
    CMD_END
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_OVERFLOW,
    ERR_UNMATCHED
  } err_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] ch;
    logic [1:0] prec;
  } cmd_t;

  function automatic logic [1:0] prec_of(input logic [7:0] ch);
    logic [1:0] p;
    case (ch)
      CH_AND, CH_OR, CH_IMPL: p = PREC_LOW;
      CH_MINUS, CH_M, CH_L:   p = PREC_HIGH;
      default:                p = PREC_NONE;
    endcase
    return p;
  endfunction

endpackage

### hw/rtl/infix_to_postfix_converter.sv
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    op_i, in_char_i
// out      output     out_valid_o / out_stall_i  out_char_o, last_o, error_o
//
// The execution unit handles each result, each push and each quietly discarded
// '(' as a step of its own.
// Whitespace is dropped at the front and costs only its transfer.
// An item's first result passes through the command queue and the output register.
// Reset clears the stack count, the command queue and the output valid flag.
// A stalled output holds the execution unit whenever it has a result to give, and the full queue then stalls the input.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [7:0] in_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_o,
  output logic [1:0] error_o
);

  logic          q_push;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  itp_pkg::cmd_t q_wdata;
  itp_pkg::cmd_t q_rdata;

  itp_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .in_char_i  (in_char_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  itp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .pop_i   (q_pop)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_rdata),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

endmodule

### hw/rtl/itp_front.sv
module itp_front (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            op_i,
  input  logic [7:0]      in_char_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output itp_pkg::cmd_t   q_data_o
);

  logic       accept;
  logic       blank;
  logic [1:0] prec;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign prec       = itp_pkg::prec_of(in_char_i);
  assign blank      = !op_i && ((in_char_i == itp_pkg::CH_TAB) ||
                                (in_char_i == itp_pkg::CH_SPACE));
  assign q_push_o   = accept && !blank;

  always_comb begin
    q_data_o.ch   = in_char_i;
    q_data_o.prec = prec;
    if (op_i) begin
      q_data_o.kind = itp_pkg::CMD_END;
    end else if (in_char_i == itp_pkg::CH_OPEN) begin
      q_data_o.kind = itp_pkg::CMD_OPEN;
    end else if (in_char_i == itp_pkg::CH_CLOSE) begin
      q_data_o.kind = itp_pkg::CMD_CLOSE;
    end else if (prec != itp_pkg::PREC_NONE) begin
      q_data_o.kind = itp_pkg::CMD_OPER;
    end else begin
      q_data_o.kind = itp_pkg::CMD_CHAR;
    end
  end

endmodule

### hw/rtl/itp_queue.sv
module itp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  itp_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          valid_o,
  output itp_pkg::cmd_t data_o,
  input  logic          pop_i
);

  localparam int unsigned AW = itp_pkg::QUEUE_AW;
  localparam int unsigned CW = itp_pkg::QUEUE_CW;

  itp_pkg::cmd_t entry_q [itp_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(itp_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + AW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/itp_back.sv
`include "assert_macros.svh"

module itp_back #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  itp_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_char_o,
  output logic          last_o,
  output logic [1:0]    error_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [7:0]    mem_q [STACK_DEPTH];
  logic [7:0]    sec_q;
  logic [7:0]    top_q, top_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rd_cnt;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          push_en;
  logic          want_push;
  logic          out_free;
  logic          stack_empty, stack_full, one_left;
  logic [1:0]    top_prec, sec_prec;

  logic            res_load;
  logic [7:0]      res_char;
  logic            res_last;
  itp_pkg::err_e   res_err;

  logic            out_valid_q;
  logic [7:0]      out_char_q;
  logic            last_q;
  itp_pkg::err_e   error_q;

  logic            err_out;
  logic            err_shape;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign stack_empty = (cnt_q == '0);
  assign stack_full  = (cnt_q == CW'(STACK_DEPTH));
  assign one_left    = (cnt_q == CW'(1));
  assign top_prec    = itp_pkg::prec_of(top_q);
  assign sec_prec    = itp_pkg::prec_of(sec_q);

  always_comb begin
    cnt_d     = cnt_q;
    top_d     = top_q;
    push_en   = 1'b0;
    want_push = 1'b0;
    cmd_pop_o = 1'b0;
    res_load  = 1'b0;
    res_char  = itp_pkg::CH_NUL;
    res_last  = 1'b0;
    res_err   = itp_pkg::ERR_NONE;
    if (cmd_valid_i) begin
      case (cmd_i.kind)
        itp_pkg::CMD_CHAR: begin
          if (out_free) begin
            res_load  = 1'b1;
            res_char  = cmd_i.ch;
            res_last  = 1'b1;
            cmd_pop_o = 1'b1;
          end
        end
        itp_pkg::CMD_OPEN: begin
          want_push = 1'b1;
        end
        itp_pkg::CMD_OPER: begin
          if (!stack_empty && (top_prec >= cmd_i.prec)) begin
            if (out_free) begin
              res_load = 1'b1;
              res_char = top_q;
              res_last = one_left || (sec_prec < cmd_i.prec);
              cnt_d    = cnt_q - CW'(1);
              top_d    = sec_q;
            end
          end else begin
            want_push = 1'b1;
          end
        end
        itp_pkg::CMD_CLOSE: begin
          if (stack_empty) begin
            if (out_free) begin
              res_load  = 1'b1;
              res_last  = 1'b1;
              res_err   = itp_pkg::ERR_UNMATCHED;
              cmd_pop_o = 1'b1;
            end
          end else if (top_q == itp_pkg::CH_OPEN) begin
            cnt_d     = cnt_q - CW'(1);
            top_d     = sec_q;
            cmd_pop_o = 1'b1;
          end else if (out_free) begin
            res_load = 1'b1;
            res_char = top_q;
            res_last = !one_left && (sec_q == itp_pkg::CH_OPEN);
            cnt_d    = cnt_q - CW'(1);
            top_d    = sec_q;
          end
        end
        itp_pkg::CMD_END: begin
          if (out_free) begin
            res_load = 1'b1;
            if (!stack_empty) begin
              res_char = top_q;
              cnt_d    = cnt_q - CW'(1);
              top_d    = sec_q;
            end else begin
              res_last  = 1'b1;
              cmd_pop_o = 1'b1;
            end
          end
        end
        default: begin
          cmd_pop_o = 1'b1;
        end
      endcase
      if (want_push) begin
        if (stack_full) begin
          if (out_free) begin
            res_load  = 1'b1;
            res_last  = 1'b1;
            res_err   = itp_pkg::ERR_OVERFLOW;
            cnt_d     = '0;
            cmd_pop_o = 1'b1;
          end
        end else begin
          push_en   = 1'b1;
          cnt_d     = cnt_q + CW'(1);
          top_d     = cmd_i.ch;
          cmd_pop_o = 1'b1;
        end
      end
    end
  end

  assign rd_cnt  = cnt_d - CW'(2);
  assign rd_addr = rd_cnt[AW-1:0];
  assign wr_addr = cnt_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem_q[wr_addr] <= cmd_i.ch;
    end
    sec_q <= mem_q[rd_addr];
    top_q <= top_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_char_q <= res_char;
      last_q     <= res_last;
      error_q    <= res_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = last_q;
  assign error_o     = error_q;

  assign err_out   = out_valid_q && (error_q != itp_pkg::ERR_NONE);
  assign err_shape = last_q && (out_char_q == itp_pkg::CH_NUL);

  `ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(STACK_DEPTH))
  `ASSERT_IMPL(a_err_shape, clk_i, rst_ni, err_out, err_shape)
  `ASSERT_NEXT(a_err_clears, clk_i, rst_ni, res_load && (res_err != itp_pkg::ERR_NONE), cnt_q == '0)

endmodule

### test/infix_to_postfix_converter_tb.sv
`timescale 1ns / 100ps

module infix_to_postfix_converter_tb;

  localparam int unsigned STACK_DEPTH  = 32;
  localparam int unsigned ITEM_TARGET  = 480;
  localparam int unsigned QUIET_TAIL   = 60;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic [7:0] OPERATORS [6] = '{
    itp_pkg::CH_AND, itp_pkg::CH_OR, itp_pkg::CH_IMPL,
    itp_pkg::CH_MINUS, itp_pkg::CH_M, itp_pkg::CH_L
  };

  typedef struct {
    logic          ch;
    logic          last;
    itp_pkg::err_e err;
  } postfix_unused_t;

  typedef struct {
    logic [7:0]    ch;
    logic          last;
    itp_pkg::err_e err;
  } postfix_out_t;

  typedef struct {
    logic       op;
    logic [7:0] ch;
  } stim_t;

  class postfix_scoreboard;
    logic [7:0]   entries [STACK_DEPTH];
    int unsigned  fill;
    postfix_out_t pending [$];
    int unsigned  errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function logic [1:0] binding_strength(logic [7:0] ch);
      if (ch == itp_pkg::CH_AND || ch == itp_pkg::CH_OR || ch == itp_pkg::CH_IMPL) begin
        return itp_pkg::PREC_LOW;
      end
      if (ch == itp_pkg::CH_MINUS || ch == itp_pkg::CH_M || ch == itp_pkg::CH_L) begin
        return itp_pkg::PREC_HIGH;
      end
      return itp_pkg::PREC_NONE;
    endfunction

    function void emit(logic [7:0] ch, itp_pkg::err_e err);
      postfix_out_t r;
      r.ch   = ch;
      r.last = 1'b0;
      r.err  = err;
      pending.push_back(r);
    endfunction

    function void stack_push(logic [7:0] ch);
      if (fill >= STACK_DEPTH) begin
        emit(itp_pkg::CH_NUL, itp_pkg::ERR_OVERFLOW);
        fill = 0;
      end else begin
        entries[fill] = ch;
        fill++;
      end
    endfunction

    function void note_input(logic op, logic [7:0] ch);
      int unsigned queued;
      logic        found;
      logic [7:0]  top;
      queued = pending.size();
      if (op) begin
        while (fill > 0) begin
          fill--;
          emit(entries[fill], itp_pkg::ERR_NONE);
        end
        emit(itp_pkg::CH_NUL, itp_pkg::ERR_NONE);
      end else if (ch == itp_pkg::CH_TAB || ch == itp_pkg::CH_SPACE) begin
      end else if (ch == itp_pkg::CH_OPEN) begin
        stack_push(ch);
      end else if (ch == itp_pkg::CH_CLOSE) begin
        found = 1'b0;
        while (fill > 0 && !found) begin
          fill--;
          top = entries[fill];
          if (top == itp_pkg::CH_OPEN) begin
            found = 1'b1;
          end else begin
            emit(top, itp_pkg::ERR_NONE);
          end
        end
        if (!found) begin
          emit(itp_pkg::CH_NUL, itp_pkg::ERR_UNMATCHED);
          fill = 0;
        end
      end else if (binding_strength(ch) != itp_pkg::PREC_NONE) begin
        while (fill > 0 && binding_strength(entries[fill - 1]) >= binding_strength(ch)) begin
          fill--;
          emit(entries[fill], itp_pkg::ERR_NONE);
        end
        stack_push(ch);
      end else begin
        emit(ch, itp_pkg::ERR_NONE);
      end
      if (pending.size() > queued) begin
        pending[pending.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_result(logic [7:0] ch, logic last, logic [1:0] err);
      postfix_out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("Unexpected result: char %02h last %0d error %0d", ch, last, err);
        end
        return;
      end
      want = pending.pop_front();
      if (want.ch !== ch || want.last !== last || want.err !== err) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("Mismatch: expected char %02h last %0d error %0d,",
                   want.ch, want.last, want.err,
                   " got char %02h last %0d error %0d", ch, last, err);
        end
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       op_i;
  logic [7:0] in_char_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_char_o;
  logic       last_o;
  logic [1:0] error_o;

  postfix_scoreboard board;
  stim_t             stim_q [$];
  int unsigned       counted = 0;
  logic              quiet_phase = 1'b0;
  int unsigned       cycle_count = 0;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .in_char_i  (in_char_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_char_o (out_char_o),
    .last_o     (last_o),
    .error_o    (error_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_item(input logic op, input logic [7:0] ch);
    stim_t item;
    item.op = op;
    item.ch = ch;
    stim_q.push_back(item);
    if (op || (ch != itp_pkg::CH_TAB && ch != itp_pkg::CH_SPACE)) begin
      counted++;
    end
  endtask

  task automatic add_token(input logic [7:0] ch);
    if ($urandom_range(0, 9) == 0) begin
      add_item(1'b0, $urandom_range(0, 1) ? itp_pkg::CH_TAB : itp_pkg::CH_SPACE);
    end
    add_item(1'b0, ch);
  endtask

  task automatic add_operand();
    if ($urandom_range(0, 4) == 0) begin
      add_token(8'($urandom_range(8'h30, 8'h39)));
    end else begin
      add_token(8'($urandom_range(8'h61, 8'h7A)));
    end
  endtask

  task automatic add_end();
    add_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // A well-formed expression, or with mangle set one whose parentheses may not balance.
  task automatic add_expression(input bit mangle);
    int unsigned terms;
    int unsigned open_depth;
    terms      = $urandom_range(1, 7);
    open_depth = 0;
    for (int unsigned t = 0; t < terms; t++) begin
      if (t > 0) begin
        add_token(OPERATORS[$urandom_range(0, 5)]);
      end
      while (open_depth < 8 && $urandom_range(0, 3) == 0) begin
        add_token(itp_pkg::CH_OPEN);
        open_depth++;
      end
      if ($urandom_range(0, 4) == 0) begin
        add_token(itp_pkg::CH_MINUS);
      end
      add_operand();
      while (open_depth > 0 && $urandom_range(0, 2) == 0) begin
        add_token(itp_pkg::CH_CLOSE);
        open_depth--;
      end
    end
    if (mangle && $urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(1, 3)) add_token(itp_pkg::CH_CLOSE);
      repeat (open_depth) add_token(itp_pkg::CH_CLOSE);
    end else if (!mangle) begin
      repeat (open_depth) add_token(itp_pkg::CH_CLOSE);
    end
    add_end();
  endtask

  // Deep nesting that usually runs the operator stack past its depth.
  task automatic add_deep_nest();
    repeat ($urandom_range(30, 44)) begin
      if ($urandom_range(0, 3) != 0) begin
        add_token(itp_pkg::CH_OPEN);
      end else begin
        add_token(OPERATORS[$urandom_range(0, 5)]);
      end
    end
    add_operand();
    if ($urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(1, 6)) add_token(itp_pkg::CH_CLOSE);
    end
    add_end();
  endtask

  task automatic add_noise();
    repeat ($urandom_range(3, 12)) begin
      add_item($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_item(input stim_t item);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= item.op;
    in_char_i  <= item.ch;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(item.op, item.ch);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(out_char_o, last_o, error_o);
    end
  end

  // The receiver holds off output transfers in bursts.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (rst_ni && !quiet_phase && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned pick;
    board = new();
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    op_i       <= 1'b0;
    in_char_i  <= itp_pkg::CH_NUL;

    add_item(1'b0, itp_pkg::CH_NUL);
    add_item(1'b0, 8'hFF);
    add_item(1'b0, itp_pkg::CH_CLOSE);
    add_item(1'b1, 8'h00);
    add_item(1'b0, itp_pkg::CH_TAB);
    add_item(1'b0, itp_pkg::CH_SPACE);
    add_item(1'b0, itp_pkg::CH_OPEN);
    add_item(1'b0, "a");
    add_item(1'b0, itp_pkg::CH_AND);
    add_item(1'b0, "b");
    add_item(1'b0, itp_pkg::CH_OR);
    add_item(1'b0, "c");
    add_item(1'b0, itp_pkg::CH_CLOSE);
    add_item(1'b0, itp_pkg::CH_M);
    add_item(1'b0, "d");
    add_item(1'b0, itp_pkg::CH_IMPL);
    add_item(1'b0, itp_pkg::CH_L);
    add_item(1'b0, "e");
    add_item(1'b0, itp_pkg::CH_MINUS);
    add_item(1'b0, itp_pkg::CH_OPEN);
    add_item(1'b0, "f");
    add_item(1'b1, 8'hFF);
    add_item(1'b0, "x");
    add_item(1'b0, itp_pkg::CH_AND);
    add_item(1'b0, itp_pkg::CH_CLOSE);

    while (counted < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        add_expression(1'b0);
      end else if (pick == 7) begin
        add_deep_nest();
      end else if (pick == 8) begin
        add_expression(1'b1);
      end else begin
        add_noise();
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_q[i]) begin
      if (i == stim_q.size() - QUIET_TAIL) begin
        quiet_phase <= 1'b1;
      end
      send_item(stim_q[i]);
    end
    in_valid_i <= 1'b0;

    while (board.pending.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
